// ===== rtl/core/rgbhsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsi_pkg
// Shared types, constants and the cos^2 degree table for the HSI converter.
// ----------------------------------------------------------------------------
package rgbhsi_pkg;

   localparam int TAB_FRAC = 46;
   localparam int TAB_LAST = 90;
   localparam int SEARCH_STEPS = 7;

   localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
   localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

   localparam logic [8:0] DEG_180 = 9'd180;
   localparam logic [8:0] DEG_179 = 9'd179;
   localparam logic [8:0] DEG_360 = 9'd360;
   localparam logic [8:0] DEG_359 = 9'd359;

   typedef logic [46:0] cos2_entry_type;
   typedef cos2_entry_type cos2_tab_type [0:90];

   // pixel state carried down the pipeline
   typedef struct packed {
      logic        grey;
      logic        n_neg;
      logic        b_gt_g;
      logic [63:0] lhs;
      logic [17:0] d4;
      logic [6:0]  cnt;
      logic [16:0] rem;
      logic [9:0]  den;
      logic [6:0]  quo;
      logic [7:0]  intensity;
   } pix_type;

   // unsigned q2.62 product
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // cos^2 of whole degrees, 46 fractional bits, built at elaboration
   function automatic cos2_tab_type build_cos2();
      logic [63:0]  c [0:89];
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  x4;
      logic [63:0]  x6;
      logic [63:0]  x8;
      logic [63:0]  sq;
      cos2_tab_type t;
      x  = PI_Q62 / 64'd180;
      x2 = mul_q62(x, x);
      x4 = mul_q62(x2, x2);
      x6 = mul_q62(x4, x2);
      x8 = mul_q62(x4, x4);
      c[0] = ONE_Q62;
      c[1] = ONE_Q62 - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720 + x8 / 64'd40320;
      for (int k = 1; k < 89; k++) begin
         c[k + 1] = (mul_q62(c[1], c[k]) << 1) - c[k - 1];
      end
      for (int k = 0; k < 90; k++) begin
         sq = mul_q62(c[k], c[k]) >> (62 - TAB_FRAC);
         t[k] = sq[46:0];
      end
      t[0]  = 47'd1 << TAB_FRAC;
      t[30] = 47'd3 << (TAB_FRAC - 2);
      t[45] = 47'd1 << (TAB_FRAC - 1);
      t[60] = 47'd1 << (TAB_FRAC - 2);
      t[90] = 47'd0;
      return t;
   endfunction

   localparam cos2_tab_type COS2_TAB = build_cos2();

endpackage

// ===== rtl/core/rgbhsi_stage.sv =====
// ----------------------------------------------------------------------------
// rgbhsi_stage
// One pipeline stage: one bit of the degree search and one quotient bit.
// ----------------------------------------------------------------------------
module rgbhsi_stage
   import rgbhsi_pkg::*;
#(
   parameter int STEP_BIT = 6
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    prev_valid,
   input  pix_type prev,
   output logic    cur_valid,
   output pix_type cur
);

   logic        valid_ff;
   pix_type     data_ff;
   pix_type     data_in;
   logic [6:0]  trial;
   logic [6:0]  idx;
   logic [64:0] prod;
   logic [16:0] dsub;

   // trial degree count and its table product
   always_comb begin
      trial = prev.cnt | (7'd1 << STEP_BIT);
      idx   = (trial <= 7'(TAB_LAST)) ? trial : 7'd0;
      prod  = {47'd0, prev.d4} * {18'd0, COS2_TAB[idx]};
      dsub  = 17'({7'd0, prev.den} << STEP_BIT);
      data_in = prev;
      if ((trial <= 7'(TAB_LAST)) && ({1'b0, prev.lhs} <= prod)) begin
         data_in.cnt = trial;
      end
      // restoring divide step
      if (prev.rem >= dsub) begin
         data_in.rem = prev.rem - dsub;
         data_in.quo = prev.quo | (7'd1 << STEP_BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign cur_valid = valid_ff;
   assign cur       = data_ff;

endmodule

// ===== rtl/core/rgb_to_hsi_pixel_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel_converter
// Converts 8-bit BGR pixels to hue degrees, saturation percent and intensity.
// ----------------------------------------------------------------------------
// the result passes through the front-end register, each search stage and the output register, in that order
// throughput: one pixel per clock; the whole pipeline holds while rsp_tready
// is low and the last stage is full (one table multiply per stage)
// reset: synchronous, clears all stage valid bits; no table fill is needed
module rgb_to_hsi_pixel_converter
   import rgbhsi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // blue[7:0], green[15:8], red[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // hue_degrees[8:0], saturation_percent[15:9], intensity[23:16]
);

   logic                 en;
   logic [7:0]           blue;
   logic [7:0]           green;
   logic [7:0]           red;
   logic [9:0]           sum;
   logic [7:0]           mn;
   logic signed [10:0]   n;
   logic [17:0]          n2;
   logic signed [8:0]    drg;
   logic signed [8:0]    drb;
   logic signed [8:0]    dgb;
   logic signed [18:0]   dval;
   logic [19:0]          isum;
   pix_type              s0_in;
   logic                 s0_valid_ff;
   pix_type              s0_ff;
   logic                 sv [0:SEARCH_STEPS];
   pix_type              sd [0:SEARCH_STEPS];
   logic [64:0]          eprod;
   logic                 exact;
   logic [8:0]           cnt9;
   logic [8:0]           tfloor;
   logic [8:0]           hue_in;
   logic                 out_valid_ff;
   logic [8:0]           hue_ff;
   logic [6:0]           sat_ff;
   logic [7:0]           int_ff;

   // whole pipeline advances unless the result is stuck
   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   assign blue  = req_tdata[7:0];
   assign green = req_tdata[15:8];
   assign red   = req_tdata[23:16];

   // front end: sums, min, numerator and denominator of the angle
   always_comb begin
      sum = {2'd0, blue} + {2'd0, green} + {2'd0, red};
      mn  = (red < green) ? red : green;
      if (blue < mn) begin
         mn = blue;
      end
      n    = 11'sd2 * $signed({3'd0, red}) - $signed({3'd0, green}) - $signed({3'd0, blue});
      n2   = 18'(n * n);
      drg  = $signed({1'b0, red}) - $signed({1'b0, green});
      drb  = $signed({1'b0, red}) - $signed({1'b0, blue});
      dgb  = $signed({1'b0, green}) - $signed({1'b0, blue});
      dval = 19'(drg * drg) + 19'(drb * dgb);
      isum = {10'd0, sum} * 20'd683;
      s0_in.grey      = (blue == green) && (green == red);
      s0_in.n_neg     = n < 0;
      s0_in.b_gt_g    = blue > green;
      s0_in.lhs       = {n2, 46'd0};
      s0_in.d4        = {dval[15:0], 2'b00};
      s0_in.cnt       = 7'd0;
      s0_in.rem       = 17'(7'd100 * (sum - 10'd3 * {2'd0, mn}));
      s0_in.den       = sum;
      s0_in.quo       = 7'd0;
      s0_in.intensity = isum[18:11];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= s0_in;
      end
   end

   assign sv[0] = s0_valid_ff;
   assign sd[0] = s0_ff;

   // one search bit and one quotient bit per stage, high bit first
   for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_step
      rgbhsi_stage #(
         .STEP_BIT(SEARCH_STEPS - 1 - i)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .prev_valid (sv[i]),
         .prev       (sd[i]),
         .cur_valid  (sv[i + 1]),
         .cur        (sd[i + 1])
      );
   end

   // exact-angle check and quadrant unfolding
   always_comb begin
      eprod  = {47'd0, sd[SEARCH_STEPS].d4} * {18'd0, COS2_TAB[sd[SEARCH_STEPS].cnt]};
      exact  = {1'b0, sd[SEARCH_STEPS].lhs} == eprod;
      cnt9   = {2'd0, sd[SEARCH_STEPS].cnt};
      if (sd[SEARCH_STEPS].n_neg) begin
         tfloor = exact ? DEG_180 - cnt9 : DEG_179 - cnt9;
      end else begin
         tfloor = cnt9;
      end
      if (sd[SEARCH_STEPS].b_gt_g) begin
         hue_in = exact ? DEG_360 - tfloor : DEG_359 - tfloor;
      end else begin
         hue_in = tfloor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= sv[SEARCH_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff <= sd[SEARCH_STEPS].grey ? 9'd0 : hue_in;
         sat_ff <= sd[SEARCH_STEPS].grey ? 7'd0 : sd[SEARCH_STEPS].quo;
         int_ff <= sd[SEARCH_STEPS].intensity;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {int_ff, sat_ff, hue_ff};

endmodule
